// ===== rtl/pidpwm_pkg.sv =====
package pidpwm_pkg;

    // Field and datapath widths.
    localparam int POS_W    = 32;
    localparam int GAIN_W   = 32;
    localparam int INTEG_W  = 48;
    localparam int DIFF_W   = 33;
    localparam int ACC_W    = 64;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = 26;
    localparam int SCALED_W = 18;
    localparam int Q_W      = 8;
    localparam int PWM_W    = 9;
    localparam int BAND_W   = 8;
    localparam int SETTLE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Saturation limits and scaling constants.
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [ACC_W-1:0]   TERM_LIM  = 64'sh2000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0]   OUT_LIM_Q = 64'sd65536000;
    localparam logic [MUL_W-1:0]          PWM_SCALE = 33'd255;
    // Reciprocal of 1000 scaled by 2^28, rounded up; exact for values below 2^18.
    localparam logic [MUL_W-1:0]          RECIP_K   = 33'd268436;
    localparam int                        RECIP_SH  = 28;
    localparam logic [SETTLE_W-1:0]       SETTLE_RESET = 16'd10;
    localparam logic [SETTLE_W-1:0]       SETTLE_SAT   = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_INTEG  = 3'd1,
        REG_GAIN_DERIV  = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_SETTLE      = 3'd4,
        REG_TARGET      = 3'd5
    } reg_idx_t;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0_0000_0000_0001,
        ST_INTEG = 13'b0_0000_0000_0010,
        ST_MP    = 13'b0_0000_0000_0100,
        ST_MD    = 13'b0_0000_0000_1000,
        ST_MIH   = 13'b0_0000_0001_0000,
        ST_MIL   = 13'b0_0000_0010_0000,
        ST_TI    = 13'b0_0000_0100_0000,
        ST_SUM   = 13'b0_0000_1000_0000,
        ST_CLAMP = 13'b0_0001_0000_0000,
        ST_SCALE = 13'b0_0010_0000_0000,
        ST_RECIP = 13'b0_0100_0000_0000,
        ST_PWM   = 13'b0_1000_0000_0000,
        ST_OUT   = 13'b1_0000_0000_0000
    } state_t;

endpackage

// ===== rtl/pidpwm_mul.sv =====
module pidpwm_mul
    import pidpwm_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    // Shared signed multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

endmodule

// ===== rtl/pid_position_to_pwm_with_settle_top.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_command, s_position
// m_       out        m_valid / m_ready  m_pwm_drive, m_error_remaining, m_in_band,
//                                        m_finished, m_cancelled
// cfg_     in         cfg_we             cfg_index, cfg_data
//
// Samples, starts and ticks that do no arithmetic leave the sequencer idle; a cancel goes
// through the output state, and in a control tick four gain products and two scaling products
// pass one at a time through the single registered 33 x 33 multiplier under the sequencer.
// Reset is synchronous and active low; it restores the register defaults and clears
// the controller state. A result waits in the output register while the next item is
// taken; a new result stalls in its final state until that register is free.
module pid_position_to_pwm_with_settle_top
    import pidpwm_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic signed [POS_W-1:0]      s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [PWM_W-1:0]      m_pwm_drive,
    output logic signed [POS_W-1:0]      m_error_remaining,
    output logic                         m_in_band,
    output logic                         m_finished,
    output logic                         m_cancelled
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_prop_reg;
    logic signed [GAIN_W-1:0] gain_integ_reg;
    logic signed [GAIN_W-1:0] gain_deriv_reg;
    logic [BAND_W-1:0]        dead_band_reg;
    logic [SETTLE_W-1:0]      settle_ticks_reg;
    logic signed [POS_W-1:0]  target_reg;

    // Controller state.
    state_t                   state_reg, state_next;
    logic signed [POS_W-1:0]  present_reg;
    logic signed [POS_W-1:0]  previous_reg;
    logic                     have_sample_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [SETTLE_W-1:0]      settle_cnt_reg;
    logic                     goal_active_reg;
    logic                     m_valid_reg;

    // Working registers.
    logic signed [POS_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  ti_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic signed [PWM_W-1:0]  res_pwm_reg;
    logic                     res_band_reg;
    logic                     res_fin_reg;
    logic                     res_cancel_reg;
    logic signed [PWM_W-1:0]  m_pwm_reg;
    logic signed [POS_W-1:0]  m_err_reg;
    logic                     m_band_reg;
    logic                     m_fin_reg;
    logic                     m_cancel_reg;

    // Multiplier operands and product.
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     s_accept;
    logic                     out_free;
    cmd_t                     cmd;
    logic                     tick_runs;
    logic signed [DIFF_W-1:0] err_diff;
    logic signed [POS_W-1:0]  err_sat;
    logic signed [INTEG_W:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [ACC_W-1:0]  prod_shift;
    logic signed [ACC_W-1:0]  ti_sat;
    logic [MAG_W-1:0]         mag_val;
    logic [Q_W-1:0]           q_val;
    logic                     band;
    logic [SETTLE_W-1:0]      cnt_inc;
    logic                     fin;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cmd      = cmd_t'(s_command);
    assign tick_runs = have_sample_reg && goal_active_reg && (settle_ticks_reg != '0);

    // Error against the target, saturated to 32 bits.
    always_comb begin
        err_diff = DIFF_W'(present_reg) - DIFF_W'(target_reg);
        if (err_diff[DIFF_W-1] != err_diff[DIFF_W-2]) begin
            err_sat = err_diff[DIFF_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                         : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            err_sat = err_diff[POS_W-1:0];
        end
    end

    // Saturating integral update.
    always_comb begin
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // Product shifted down by the fraction width, rounding toward minus infinity.
    assign prod_shift = ACC_W'(signed'(prod_reg[PROD_W-1:FRAC_W]));

    // Integral term limited before the sum.
    always_comb begin
        if (ti_reg > TERM_LIM) begin
            ti_sat = TERM_LIM;
        end else if (ti_reg < -TERM_LIM) begin
            ti_sat = -TERM_LIM;
        end else begin
            ti_sat = ti_reg;
        end
    end

    // Magnitude of the sum after the output clamp.
    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            mag_val = (acc_reg < -OUT_LIM_Q) ? MAG_W'(OUT_LIM_Q) : MAG_W'(-acc_reg);
        end else begin
            mag_val = (acc_reg > OUT_LIM_Q) ? MAG_W'(OUT_LIM_Q) : MAG_W'(acc_reg);
        end
    end

    // Drive magnitude, dead band test and settle count.
    assign q_val   = prod_reg[RECIP_SH+Q_W-1:RECIP_SH];
    assign band    = (q_val <= dead_band_reg);
    assign cnt_inc = (settle_cnt_reg == SETTLE_SAT) ? settle_cnt_reg : settle_cnt_reg + 1'b1;
    assign fin     = band && (cnt_inc >= settle_ticks_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MP: begin
                mul_a = MUL_W'(gain_prop_reg);
                mul_b = MUL_W'(err_reg);
            end
            ST_MD: begin
                mul_a = MUL_W'(gain_deriv_reg);
                mul_b = deriv_reg;
            end
            ST_MIH: begin
                mul_a = MUL_W'(gain_integ_reg);
                mul_b = MUL_W'(signed'(integ_reg[INTEG_W-1:FRAC_W]));
            end
            ST_MIL: begin
                mul_a = MUL_W'(gain_integ_reg);
                mul_b = {{(MUL_W-FRAC_W){1'b0}}, integ_reg[FRAC_W-1:0]};
            end
            ST_SCALE: begin
                mul_a = {{(MUL_W-MAG_W){1'b0}}, mag_reg};
                mul_b = PWM_SCALE;
            end
            ST_RECIP: begin
                mul_a = {{(MUL_W-SCALED_W){1'b0}}, prod_reg[FRAC_W+SCALED_W-1:FRAC_W]};
                mul_b = RECIP_K;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidpwm_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (cmd == CMD_CANCEL) begin
                        state_next = ST_OUT;
                    end else if (cmd == CMD_TICK && tick_runs) begin
                        state_next = ST_INTEG;
                    end
                end
            end
            ST_INTEG: state_next = ST_MP;
            ST_MP:    state_next = ST_MD;
            ST_MD:    state_next = ST_MIH;
            ST_MIH:   state_next = ST_MIL;
            ST_MIL:   state_next = ST_TI;
            ST_TI:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_PWM;
            ST_PWM:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and controller registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            gain_prop_reg    <= '0;
            gain_integ_reg   <= '0;
            gain_deriv_reg   <= '0;
            dead_band_reg    <= '0;
            settle_ticks_reg <= SETTLE_RESET;
            target_reg       <= '0;
            present_reg      <= '0;
            previous_reg     <= '0;
            have_sample_reg  <= 1'b0;
            integ_reg        <= '0;
            settle_cnt_reg   <= '0;
            goal_active_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN_PROP:  gain_prop_reg    <= cfg_data;
                    REG_GAIN_INTEG: gain_integ_reg   <= cfg_data;
                    REG_GAIN_DERIV: gain_deriv_reg   <= cfg_data;
                    REG_DEAD_BAND:  dead_band_reg    <= cfg_data[BAND_W-1:0];
                    REG_SETTLE:     settle_ticks_reg <= cfg_data[SETTLE_W-1:0];
                    REG_TARGET:     target_reg       <= cfg_data;
                    default: ;
                endcase
            end

            if (s_accept) begin
                unique case (cmd)
                    CMD_SAMPLE: begin
                        previous_reg    <= have_sample_reg ? present_reg : s_position;
                        present_reg     <= s_position;
                        have_sample_reg <= 1'b1;
                    end
                    CMD_START: begin
                        integ_reg       <= '0;
                        settle_cnt_reg  <= '0;
                        goal_active_reg <= (settle_ticks_reg != '0);
                    end
                    CMD_TICK: begin
                        // A zero settle limit closes the goal without a result.
                        if (have_sample_reg && goal_active_reg && settle_ticks_reg == '0) begin
                            goal_active_reg <= 1'b0;
                        end
                    end
                    CMD_CANCEL: goal_active_reg <= 1'b0;
                    default: ;
                endcase
            end

            if (state_reg == ST_INTEG) begin
                integ_reg <= integ_sat;
            end

            if (state_reg == ST_PWM) begin
                settle_cnt_reg <= band ? cnt_inc : '0;
                if (fin) begin
                    goal_active_reg <= 1'b0;
                end
            end

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic and result registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (cmd == CMD_CANCEL) begin
                err_reg        <= '0;
                res_pwm_reg    <= '0;
                res_band_reg   <= 1'b0;
                res_fin_reg    <= 1'b0;
                res_cancel_reg <= 1'b1;
            end else begin
                err_reg        <= err_sat;
                res_cancel_reg <= 1'b0;
            end
        end

        unique case (state_reg)
            ST_INTEG: deriv_reg <= DIFF_W'(present_reg) - DIFF_W'(previous_reg);
            ST_MD:    acc_reg   <= prod_shift;
            ST_MIH:   acc_reg   <= acc_reg + prod_shift;
            ST_MIL:   ti_reg    <= prod_reg[ACC_W-1:0];
            ST_TI:    ti_reg    <= ti_reg + prod_shift;
            ST_SUM:   acc_reg   <= acc_reg + ti_sat;
            ST_CLAMP: begin
                mag_reg <= mag_val;
                neg_reg <= acc_reg[ACC_W-1];
            end
            ST_PWM: begin
                if (band) begin
                    res_pwm_reg <= '0;
                end else if (neg_reg) begin
                    res_pwm_reg <= -PWM_W'(q_val);
                end else begin
                    res_pwm_reg <= PWM_W'(q_val);
                end
                res_band_reg <= band;
                res_fin_reg  <= fin;
            end
            default: ;
        endcase

        // Output register load when the previous transfer is done.
        if (state_reg == ST_OUT && out_free) begin
            m_pwm_reg    <= res_pwm_reg;
            m_err_reg    <= err_reg;
            m_band_reg   <= res_band_reg;
            m_fin_reg    <= res_fin_reg;
            m_cancel_reg <= res_cancel_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pwm_drive       = m_pwm_reg;
    assign m_error_remaining = m_err_reg;
    assign m_in_band         = m_band_reg;
    assign m_finished        = m_fin_reg;
    assign m_cancelled       = m_cancel_reg;

`ifndef SYNTHESIS
    // The drive stays inside the thruster range.
    a_pwm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pwm_drive >= -9'sd255 && m_pwm_drive <= 9'sd255))
        else $error("pwm drive out of range");

    // An in-band tick always sends zero drive.
    a_band_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_band |-> m_pwm_drive == '0)
        else $error("in-band result with nonzero drive");

    // A finish only happens on an in-band tick.
    a_fin_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_in_band)
        else $error("finish without in-band tick");

    // A cancel result carries nothing else.
    a_cancel_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cancelled |-> (m_pwm_drive == '0 && m_error_remaining == '0
            && !m_in_band && !m_finished))
        else $error("cancel result with stray fields");

    // The goal closes after a finishing tick is computed.
    a_fin_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PWM && fin |=> !goal_active_reg)
        else $error("goal still open after finish");
`endif

endmodule

// ===== test/pid_position_to_pwm_with_settle_top_test.sv =====
module pid_position_to_pwm_with_settle_top_test;
    import pidpwm_pkg::*;

    localparam int     CLK_HALF         = 4;
    localparam int     RESET_CYCLES     = 8;
    localparam int     STALL_LIMIT      = 3000;
    localparam int     DRAIN_CYCLES     = 24;
    localparam int     REPORT_LIMIT     = 40;
    localparam int     RANDOM_SET_ITEMS = 56;
    localparam int     INTEG_FILL_TICKS = 32;
    localparam longint DRIVE_MAX        = 255;
    localparam longint ERR_MAX          = 2147483647;
    localparam longint ERR_MIN          = -ERR_MAX - 1;

    typedef struct packed {
        logic signed [PWM_W-1:0] pwm;
        logic signed [POS_W-1:0] err;
        logic                    in_band;
        logic                    finished;
        logic                    cancelled;
    } drive_result_t;

    // Block ports; every input starts at a known value.
    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   cfg_data   = '0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_command  = '0;
    logic signed [POS_W-1:0] s_position = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic signed [PWM_W-1:0] m_pwm_drive;
    logic signed [POS_W-1:0] m_error_remaining;
    logic                    m_in_band;
    logic                    m_finished;
    logic                    m_cancelled;

    // Controller copy: register settings and loop state.
    logic signed [GAIN_W-1:0] kp_cfg     = '0;
    logic signed [GAIN_W-1:0] ki_cfg     = '0;
    logic signed [GAIN_W-1:0] kd_cfg     = '0;
    logic [BAND_W-1:0]        band_cfg   = '0;
    logic [SETTLE_W-1:0]      settle_cfg = SETTLE_RESET;
    logic signed [POS_W-1:0]  target_cfg = '0;
    longint pres_pos   = 0;
    longint prev_pos   = 0;
    longint integ_sum  = 0;
    bit     have_pos   = 1'b0;
    bit     goal_open  = 1'b0;
    int     settle_cnt = 0;

    drive_result_t expected_drives[$];

    int send_idle_pct   = 10;
    int recv_idle_pct   = 61;
    int mismatch_count  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int finishes_seen   = 0;
    int cancels_seen    = 0;
    int idle_cycles     = 0;

    pid_position_to_pwm_with_settle_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_position        (s_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_drive       (m_pwm_drive),
        .m_error_remaining (m_error_remaining),
        .m_in_band         (m_in_band),
        .m_finished        (m_finished),
        .m_cancelled       (m_cancelled)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Exact gain product, shifted back to Q16.16 with rounding toward minus infinity.
    function automatic longint q16_product(input logic signed [GAIN_W-1:0] gain,
                                           input longint value);
        logic signed [127:0] g_wide;
        logic signed [127:0] v_wide;
        logic signed [127:0] prod;
        g_wide = 128'(gain);
        v_wide = 128'(value);
        prod   = g_wide * v_wide;
        return longint'(prod >>> FRAC_W);
    endfunction

    function automatic logic signed [POS_W-1:0] signed_range(input logic [31:0] span);
        logic signed [POS_W-1:0] mag;
        mag = $urandom_range(span);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Mostly near the target so that the loop settles, sometimes anywhere at all.
    function automatic logic signed [POS_W-1:0] random_offset();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return signed_range(32'h0040_0000);
        end
        if (pick < 80) begin
            return signed_range(32'h0800_0000);
        end
        return $urandom;
    endfunction

    // Updates the controller copy for one accepted transfer and queues any result it causes.
    task automatic predict_controller(input cmd_t cmd, input logic signed [POS_W-1:0] pos);
        longint err, deriv, p_term, i_term, d_term, sum, drive, mag;
        drive_result_t res;
        res = '0;
        case (cmd)
            CMD_SAMPLE: begin
                prev_pos = have_pos ? pres_pos : longint'(pos);
                pres_pos = longint'(pos);
                have_pos = 1'b1;
            end
            CMD_START: begin
                integ_sum  = 0;
                settle_cnt = 0;
                goal_open  = (settle_cfg != 0);
            end
            CMD_CANCEL: begin
                goal_open     = 1'b0;
                res.cancelled = 1'b1;
                expected_drives.push_back(res);
            end
            CMD_TICK: begin
                if (have_pos && goal_open) begin
                    if (settle_cfg == 0) begin
                        // A zero settle count closes the goal without a result.
                        goal_open = 1'b0;
                    end else begin
                        err       = clamp(pres_pos - longint'(target_cfg), ERR_MIN, ERR_MAX);
                        integ_sum = clamp(integ_sum + err, INTEG_MIN, INTEG_MAX);
                        deriv     = pres_pos - prev_pos;
                        p_term    = clamp(q16_product(kp_cfg, err), -TERM_LIM, TERM_LIM);
                        i_term    = clamp(q16_product(ki_cfg, integ_sum), -TERM_LIM, TERM_LIM);
                        d_term    = clamp(q16_product(kd_cfg, deriv), -TERM_LIM, TERM_LIM);
                        sum       = clamp(p_term + i_term + d_term, -OUT_LIM_Q, OUT_LIM_Q);
                        drive     = clamp((sum * DRIVE_MAX) / OUT_LIM_Q, -DRIVE_MAX, DRIVE_MAX);
                        mag       = (drive < 0) ? -drive : drive;
                        res.err     = POS_W'(err);
                        res.in_band = (mag <= longint'(band_cfg));
                        if (res.in_band) begin
                            drive = 0;
                            if (settle_cnt < int'(SETTLE_SAT)) begin
                                settle_cnt++;
                            end
                            if (settle_cnt >= int'(settle_cfg)) begin
                                res.finished = 1'b1;
                                goal_open    = 1'b0;
                            end
                        end else begin
                            settle_cnt = 0;
                        end
                        res.pwm = PWM_W'(drive);
                        expected_drives.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // Samples at the falling edge what the next rising edge will take: results are checked
    // first, then an input transfer updates the controller copy.
    always @(negedge aclk) begin
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drives.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_drives.pop_front();
                if (m_pwm_drive !== want.pwm) begin
                    report_mismatch($sformatf("pwm_drive got %0d want %0d",
                                              m_pwm_drive, want.pwm));
                end
                if (m_error_remaining !== want.err) begin
                    report_mismatch($sformatf("error_remaining got %0d want %0d",
                                              m_error_remaining, want.err));
                end
                if (m_in_band !== want.in_band) begin
                    report_mismatch($sformatf("in_band got %b want %b", m_in_band, want.in_band));
                end
                if (m_finished !== want.finished) begin
                    report_mismatch($sformatf("finished got %b want %b",
                                              m_finished, want.finished));
                end
                if (m_cancelled !== want.cancelled) begin
                    report_mismatch($sformatf("cancelled got %b want %b",
                                              m_cancelled, want.cancelled));
                end
                results_checked++;
                if (want.finished) begin
                    finishes_seen++;
                end
                if (want.cancelled) begin
                    cancels_seen++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predict_controller(cmd_t'(s_command), s_position);
            items_accepted++;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("pid_position_to_pwm_with_settle_top_test: errors");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Offers one item and returns at the edge where its transfer takes place.
    task automatic send_command(input cmd_t cmd, input logic signed [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_position <= pos;
        @(negedge aclk);
        while (!s_ready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    // Waits for every queued result, then for a tick that may still be running silently.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_drives.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_GAIN_PROP:  kp_cfg     = value;
            REG_GAIN_INTEG: ki_cfg     = value;
            REG_GAIN_DERIV: kd_cfg     = value;
            REG_DEAD_BAND:  band_cfg   = value[BAND_W-1:0];
            REG_SETTLE:     settle_cfg = value[SETTLE_W-1:0];
            REG_TARGET:     target_cfg = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic signed [GAIN_W-1:0] kp,
                                 input logic signed [GAIN_W-1:0] ki,
                                 input logic signed [GAIN_W-1:0] kd,
                                 input logic [BAND_W-1:0] band,
                                 input logic [SETTLE_W-1:0] settle,
                                 input logic signed [POS_W-1:0] target);
        write_register(REG_GAIN_PROP, kp);
        write_register(REG_GAIN_INTEG, ki);
        write_register(REG_GAIN_DERIV, kd);
        write_register(REG_DEAD_BAND, {24'd0, band});
        write_register(REG_SETTLE, {16'd0, settle});
        write_register(REG_TARGET, target);
    endtask

    // Register defaults: ticks and cancels before the first sample, then the first sample.
    task automatic test_reset_state();
        send_command(CMD_TICK, 32'sh7FFF_FFFF);
        send_command(CMD_CANCEL, '0);
        send_command(CMD_START, '1);
        send_command(CMD_TICK, '0);
        send_command(CMD_SAMPLE, 32'sh7FFF_FFFF);
        send_command(CMD_TICK, 32'sh8000_0000);
        wait_until_drained();
    endtask

    // Extreme gains and target: a finish in one tick, error saturation, clamped drive.
    task automatic test_gain_extremes();
        load_settings(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 8'd255, 16'd1,
                      32'sh8000_0000);
        send_command(CMD_START, '0);
        send_command(CMD_SAMPLE, 32'sh8000_0000);
        send_command(CMD_TICK, '0);
        send_command(CMD_SAMPLE, 32'sh7FFF_FFFF);
        send_command(CMD_TICK, '1);
        wait_until_drained();
        write_register(REG_DEAD_BAND, '0);
        write_register(REG_SETTLE, 32'h0000_FFFF);
        send_command(CMD_START, '0);
        send_command(CMD_TICK, '0);
        send_command(CMD_TICK, '1);
        wait_until_drained();
    endtask

    // A zero settle count at start and at a tick, then a two-tick finish and a cancel.
    task automatic test_zero_settle();
        write_register(REG_SETTLE, '0);
        send_command(CMD_START, '0);
        send_command(CMD_TICK, '0);
        wait_until_drained();
        write_register(REG_SETTLE, 32'd3);
        send_command(CMD_START, '0);
        wait_until_drained();
        write_register(REG_SETTLE, '0);
        send_command(CMD_TICK, '0);
        send_command(CMD_TICK, '0);
        wait_until_drained();
        write_register(REG_SETTLE, 32'd2);
        write_register(REG_DEAD_BAND, 32'd255);
        send_command(CMD_START, '0);
        send_command(CMD_TICK, '0);
        send_command(CMD_TICK, '0);
        send_command(CMD_CANCEL, '1);
        wait_until_drained();
    endtask

    // One random register set followed by goal sequences with random content and some noise.
    task automatic test_random_control(input int set_no, input int count);
        logic signed [GAIN_W-1:0] kp, ki, kd;
        logic signed [POS_W-1:0]  target, pos;
        logic [BAND_W-1:0]        band;
        logic [SETTLE_W-1:0]      settle;
        cmd_t cmd;
        int   sent, pick;
        kp     = signed_range(32'h0003_0000);
        ki     = signed_range(32'h0000_0800);
        kd     = signed_range(32'h0002_0000);
        band   = BAND_W'($urandom_range(40));
        settle = SETTLE_W'($urandom_range(5, 1));
        target = signed_range(32'h0100_0000);
        case (set_no)
            0: begin
                band   = 8'd255;
                settle = 16'd1;
            end
            1: begin
                band   = '0;
                settle = 16'hFFFF;
            end
            2: begin
                kp     = 32'sh7FFF_FFFF;
                target = 32'sh7FFF_FFFF;
            end
            3: begin
                ki     = 32'sh8000_0000;
                kd     = 32'sh8000_0000;
                target = 32'sh8000_0000;
            end
            default: ;
        endcase
        wait_until_drained();
        load_settings(kp, ki, kd, band, settle, target);
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (!have_pos) begin
                cmd = (pick < 80) ? CMD_SAMPLE : cmd_t'($urandom_range(3));
            end else if (!goal_open) begin
                if (pick < 65) begin
                    cmd = CMD_START;
                end else if (pick < 75) begin
                    cmd = CMD_TICK;
                end else if (pick < 85) begin
                    cmd = CMD_CANCEL;
                end else begin
                    cmd = CMD_SAMPLE;
                end
            end else begin
                if (pick < 40) begin
                    cmd = CMD_SAMPLE;
                end else if (pick < 88) begin
                    cmd = CMD_TICK;
                end else if (pick < 94) begin
                    cmd = CMD_START;
                end else begin
                    cmd = CMD_CANCEL;
                end
            end
            if (cmd == CMD_SAMPLE) begin
                // An occasional repeated position gives a zero derivative.
                if ($urandom_range(9) == 0) begin
                    pos = POS_W'(pres_pos);
                end else begin
                    pos = target + random_offset();
                end
            end else begin
                pos = $urandom;
            end
            // Ticks that the block ignores do not count toward the item total.
            if (cmd != CMD_TICK || (have_pos && goal_open)) begin
                sent++;
            end
            send_command(cmd, pos);
        end
        wait_until_drained();
    endtask

    // Run of saturated errors that builds a large integral; the proportional gain has the
    // opposite sign, so the two terms pull against each other in the sum.
    task automatic test_integral_saturation();
        load_settings(32'sh8000_0000, 32'sh0000_8000, '0, '0, 16'hFFFF, 32'sh8000_0000);
        send_command(CMD_SAMPLE, 32'sh7FFF_FFFF);
        send_command(CMD_START, '0);
        repeat (INTEG_FILL_TICKS) send_command(CMD_TICK, '0);
        send_command(CMD_CANCEL, '0);
        wait_until_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(10, 61);
        test_reset_state();
        test_gain_extremes();
        test_zero_settle();
        test_random_control(0, RANDOM_SET_ITEMS);
        test_random_control(1, RANDOM_SET_ITEMS);

        set_idling(61, 10);
        test_random_control(2, RANDOM_SET_ITEMS);
        test_random_control(3, RANDOM_SET_ITEMS);

        set_idling(0, 0);
        test_random_control(4, RANDOM_SET_ITEMS);
        test_random_control(5, RANDOM_SET_ITEMS);
        test_integral_saturation();

        $display("covered %0d input transfers and %0d checked results (%0d finishes, %0d cancels)",
                 items_accepted, results_checked, finishes_seen, cancels_seen);
        $display("directed extremes, six random register sets, %0d-tick run of saturated errors",
                 INTEG_FILL_TICKS);
        if (mismatch_count == 0 && expected_drives.size() == 0) begin
            $display("pid_position_to_pwm_with_settle_top_test: clean");
        end else begin
            $display("pid_position_to_pwm_with_settle_top_test: errors");
        end
        $finish;
    end

endmodule

// ===== pid_position_to_pwm_with_settle_top.f =====
rtl/pidpwm_pkg.sv
rtl/pidpwm_mul.sv
rtl/pid_position_to_pwm_with_settle_top.sv
test/pid_position_to_pwm_with_settle_top_test.sv
